// ----- sv/selt_pkg.sv -----
package selt_pkg;

  localparam int unsigned LOG_DEPTH = 256;

  localparam logic [1:0] ACT_LOG   = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] block_addr;
    logic [1:0]  drive_unit;
    logic [2:0]  error_bits;
    logic [7:0]  read_index;
  } item_t;

  typedef struct packed {
    logic [8:0]  entry_count;
    logic        merged;
    logic        dropped;
    logic        rec_valid;
    logic [31:0] rec_addr;
    logic [1:0]  rec_unit;
    logic [2:0]  rec_bits;
    logic [15:0] rec_count;
  } result_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [1:0]  unit;
    logic [2:0]  bits;
    logic [15:0] count;
  } rec_t;

  localparam int unsigned REC_W = $bits(rec_t);

endpackage

// ----- sv/selt_ram.sv -----
module selt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- sv/sorted_error_log_table.sv -----
// Sorted disk error log. Records (address, unit, type bits, saturating count)
// are kept in one RAM in ascending address order. Raise start_i while busy_o
// is low to hand in an item; exactly one result follows, shown on result_o for
// a single cycle with res_valid_o high. The receiver cannot stall: capture the
// result in that cycle. Clear, an unknown action and a read past the end are
// answered from the idle state; a read of a live record waits on the
// registered RAM read. A log item reads and then compares each record scanned;
// a merge then writes the record back, a drop on a full table answers from the
// insert state, and an insert moves each later record up with a read and a
// write, then writes the new record. The worst case is an insert at the front
// of a table holding LOG_DEPTH-1 records. The single RAM port pair sets
// the pace: the scan compares one record per read, and the insert moves one
// record per read/write pair. No clearing pass is needed after reset.
module sorted_error_log_table #(
  parameter int unsigned LOG_DEPTH = selt_pkg::LOG_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  selt_pkg::item_t   item_i,
  output logic              busy_o,
  output logic              res_valid_o,
  output selt_pkg::result_t result_o
);

  localparam int unsigned AW = $clog2(LOG_DEPTH);
  localparam int unsigned CW = $clog2(LOG_DEPTH + 1);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SCAN_RD  = 3'd1;
  localparam logic [2:0] S_SCAN_CK  = 3'd2;
  localparam logic [2:0] S_INSERT   = 3'd3;
  localparam logic [2:0] S_SHIFT_RD = 3'd4;
  localparam logic [2:0] S_SHIFT_WR = 3'd5;
  localparam logic [2:0] S_READ_WT  = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [CW-1:0]     used_q, used_d;
  logic [CW-1:0]     pos_q, pos_d;
  logic [CW-1:0]     k_q, k_d;
  selt_pkg::item_t   item_q, item_d;
  logic              res_valid_q, res_valid_d;
  selt_pkg::result_t res_q, res_d;

  logic                       we;
  logic [AW-1:0]              waddr, raddr;
  selt_pkg::rec_t             wrec, rrec;
  logic [selt_pkg::REC_W-1:0] rdata;

  selt_ram #(
    .WIDTH (selt_pkg::REC_W),
    .DEPTH (LOG_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wrec),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rrec = rdata;

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    pos_d       = pos_q;
    k_d         = k_q;
    item_d      = item_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    we          = 1'b0;
    waddr       = pos_q[AW-1:0];
    wrec        = rrec;
    raddr       = pos_q[AW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          item_d = item_i;
          res_d  = '0;
          unique case (item_i.action)
            selt_pkg::ACT_LOG: begin
              pos_d   = '0;
              state_d = (used_q == '0) ? S_INSERT : S_SCAN_RD;
            end
            selt_pkg::ACT_CLEAR: begin
              used_d            = '0;
              res_d.entry_count = '0;
              res_valid_d       = 1'b1;
            end
            selt_pkg::ACT_READ: begin
              raddr = AW'(item_i.read_index);
              if (32'(item_i.read_index) < 32'(used_q)) begin
                state_d = S_READ_WT;
              end else begin
                res_d.entry_count = 9'(used_q);
                res_valid_d       = 1'b1;
              end
            end
            default: begin
              res_d.entry_count = 9'(used_q);
              res_valid_d       = 1'b1;
            end
          endcase
        end
      end

      S_SCAN_RD: begin
        // issue the read; compare next cycle
        state_d = S_SCAN_CK;
      end

      S_SCAN_CK: begin
        if (item_q.block_addr < rrec.addr) begin
          state_d = S_INSERT;
        end else if (item_q.block_addr == rrec.addr && item_q.drive_unit == rrec.unit) begin
          we         = 1'b1;
          wrec       = rrec;
          wrec.bits  = rrec.bits | item_q.error_bits;
          wrec.count = (rrec.count == selt_pkg::COUNT_MAX) ? rrec.count : rrec.count + 16'd1;
          res_d.merged      = 1'b1;
          res_d.entry_count = 9'(used_q);
          res_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end else if (pos_q + CW'(1) == used_q) begin
          pos_d   = used_q;
          state_d = S_INSERT;
        end else begin
          pos_d   = pos_q + CW'(1);
          state_d = S_SCAN_RD;
        end
      end

      S_INSERT: begin
        if (32'(used_q) == 32'(LOG_DEPTH)) begin
          res_d.dropped     = 1'b1;
          res_d.entry_count = 9'(used_q);
          res_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end else begin
          k_d     = used_q;
          state_d = S_SHIFT_RD;
        end
      end

      S_SHIFT_RD: begin
        if (k_q == pos_q) begin
          we                = 1'b1;
          wrec.addr         = item_q.block_addr;
          wrec.unit         = item_q.drive_unit;
          wrec.bits         = item_q.error_bits;
          wrec.count        = 16'd1;
          used_d            = used_q + CW'(1);
          res_d.entry_count = 9'(used_q + CW'(1));
          res_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end else begin
          raddr   = AW'(k_q - CW'(1));
          state_d = S_SHIFT_WR;
        end
      end

      S_SHIFT_WR: begin
        // move the record one place up
        we      = 1'b1;
        waddr   = k_q[AW-1:0];
        wrec    = rrec;
        k_d     = k_q - CW'(1);
        state_d = S_SHIFT_RD;
      end

      S_READ_WT: begin
        res_d.rec_valid   = 1'b1;
        res_d.rec_addr    = rrec.addr;
        res_d.rec_unit    = rrec.unit;
        res_d.rec_bits    = rrec.bits;
        res_d.rec_count   = rrec.count;
        res_d.entry_count = 9'(used_q);
        res_valid_d       = 1'b1;
        state_d           = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    k_q    <= k_d;
    item_q <= item_d;
    res_q  <= res_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign result_o    = res_q;

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps

module tb;

  // Action code with no function; the block must leave the table alone.
  localparam logic [1:0] ACT_NONE = 2'd3;

  localparam int unsigned N_PHASES = 4;
  localparam int unsigned PHASE_ITEMS = 212;
  localparam int unsigned POOL_SIZE = 8;
  // Worst log item: a scan and a shift that together cover the whole table.
  localparam int unsigned SETTLE_CYCLES = 2 * selt_pkg::LOG_DEPTH + 8;

  // Percent of cycles in which the sender holds start low, per phase.
  // Phase 2 would stall the receiver, but results cannot be held off, so
  // it runs the sender flat out like phase 0.
  localparam int unsigned SEND_IDLE_PCT [N_PHASES] = '{0, 77, 0, 10};

  // One row of the directed table: stimulus plus an optional typed result.
  typedef struct packed {
    logic              typed;
    selt_pkg::result_t want;
    selt_pkg::item_t   stim;
  } dir_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  selt_pkg::item_t   item_i;
  logic              busy_o;
  logic              res_valid_o;
  selt_pkg::result_t result_o;

  // Shadow copy of the sorted table, updated as each item is accepted.
  selt_pkg::rec_t    log_shadow [selt_pkg::LOG_DEPTH];
  int unsigned       shadow_used;

  selt_pkg::result_t pending_results [$];
  dir_row_t          dir_tab [$];
  logic [31:0]       addr_pool [POOL_SIZE];
  int unsigned       idle_pct;
  int unsigned       n_fail;

  sorted_error_log_table u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .item_i     (item_i),
    .busy_o     (busy_o),
    .res_valid_o(res_valid_o),
    .result_o   (result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic selt_pkg::item_t mk_item(logic [1:0] act, logic [31:0] addr,
                                              logic [1:0] unit, logic [2:0] bits,
                                              logic [7:0] idx);
    return {act, addr, unit, bits, idx};
  endfunction

  // Build a result with no record attached (log, clear, unknown, read past end).
  function automatic selt_pkg::result_t mk_res(int unsigned cnt, logic mg, logic dr);
    selt_pkg::result_t r;
    r = '0;
    r.entry_count = cnt[8:0];
    r.merged = mg;
    r.dropped = dr;
    return r;
  endfunction

  // Apply one item to the shadow table and return the result it must cause.
  function automatic selt_pkg::result_t next_log_result(selt_pkg::item_t it);
    selt_pkg::result_t r;
    int unsigned       pos;
    int unsigned       k;
    logic              hit;
    r = '0;
    pos = 0;
    hit = 1'b0;
    case (it.action)
      selt_pkg::ACT_LOG: begin
        // Walk records with address <= new address; stop on an exact match.
        while (!hit && pos < shadow_used && it.block_addr >= log_shadow[pos].addr) begin
          if (it.block_addr == log_shadow[pos].addr &&
              it.drive_unit == log_shadow[pos].unit) begin
            log_shadow[pos].bits = log_shadow[pos].bits | it.error_bits;
            if (log_shadow[pos].count != selt_pkg::COUNT_MAX) begin
              log_shadow[pos].count = log_shadow[pos].count + 16'd1;
            end
            hit = 1'b1;
            r.merged = 1'b1;
          end else begin
            pos++;
          end
        end
        if (!hit) begin
          if (shadow_used >= selt_pkg::LOG_DEPTH) begin
            r.dropped = 1'b1;
          end else begin
            // Shift later records up and insert after equal addresses.
            for (k = shadow_used; k > pos; k--) begin
              log_shadow[k] = log_shadow[k - 1];
            end
            log_shadow[pos] = '{it.block_addr, it.drive_unit, it.error_bits, 16'd1};
            shadow_used++;
          end
        end
      end
      selt_pkg::ACT_CLEAR: begin
        shadow_used = 0;
      end
      selt_pkg::ACT_READ: begin
        if (it.read_index < shadow_used) begin
          r.rec_valid = 1'b1;
          r.rec_addr = log_shadow[it.read_index].addr;
          r.rec_unit = log_shadow[it.read_index].unit;
          r.rec_bits = log_shadow[it.read_index].bits;
          r.rec_count = log_shadow[it.read_index].count;
        end
      end
      default: begin
      end
    endcase
    r.entry_count = shadow_used[8:0];
    return r;
  endfunction

  // Reseed the address pool; the extreme address shows up now and then.
  function automatic void refresh_pool();
    int unsigned i;
    for (i = 0; i < POOL_SIZE; i++) begin
      addr_pool[i] = ($urandom_range(9) == 0) ? 32'hFFFF_FFFF : 32'($urandom);
    end
  endfunction

  // Mix fresh addresses with pool hits (merges, equal-address inserts) and
  // near neighbors of pool entries (ordering around equal keys).
  function automatic logic [31:0] pick_addr();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 40) begin
      return 32'($urandom);
    end else if (roll < 80) begin
      return addr_pool[$urandom_range(POOL_SIZE - 1)];
    end else begin
      return addr_pool[$urandom_range(POOL_SIZE - 1)] + 32'($urandom_range(4)) - 32'd2;
    end
  endfunction

  function automatic selt_pkg::item_t random_item();
    selt_pkg::item_t it;
    int unsigned     roll;
    // Randomize every field, including the ones the action ignores.
    it = mk_item(selt_pkg::ACT_LOG, 32'($urandom), 2'($urandom_range(3)),
                 3'($urandom_range(7)), 8'($urandom_range(255)));
    roll = $urandom_range(99);
    if (roll < 65) begin
      it.block_addr = pick_addr();
    end else if (roll < 93) begin
      it.action = selt_pkg::ACT_READ;
      // Mostly aim at live records or just past the end.
      if ($urandom_range(4) != 0) begin
        it.read_index = 8'($urandom_range(shadow_used > 255 ? 255 : shadow_used));
      end
    end else if (roll < 95) begin
      it.action = selt_pkg::ACT_CLEAR;
      refresh_pool();
    end else begin
      it.action = ACT_NONE;
    end
    return it;
  endfunction

  // Hand one item to the block, then record what it must produce.
  task automatic issue(input selt_pkg::item_t it, input logic typed,
                       input selt_pkg::result_t want);
    selt_pkg::result_t exp_res;
    // Hold start low for a random stretch, only if at least one idle cycle.
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    start_i <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy_o);
    exp_res = next_log_result(it);
    pending_results.push_back(typed ? want : exp_res);
  endtask

  // Drop start and hold off until every pending result has come back.
  task automatic drain();
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_result(input selt_pkg::result_t want, input selt_pkg::result_t got);
    if (got.entry_count !== want.entry_count) begin
      $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
      n_fail++;
    end
    if (got.merged !== want.merged) begin
      $error("merged: expected %0b, got %0b", want.merged, got.merged);
      n_fail++;
    end
    if (got.dropped !== want.dropped) begin
      $error("dropped: expected %0b, got %0b", want.dropped, got.dropped);
      n_fail++;
    end
    if (got.rec_valid !== want.rec_valid) begin
      $error("rec_valid: expected %0b, got %0b", want.rec_valid, got.rec_valid);
      n_fail++;
    end
    if (got.rec_addr !== want.rec_addr) begin
      $error("rec_addr: expected %h, got %h", want.rec_addr, got.rec_addr);
      n_fail++;
    end
    if (got.rec_unit !== want.rec_unit) begin
      $error("rec_unit: expected %0d, got %0d", want.rec_unit, got.rec_unit);
      n_fail++;
    end
    if (got.rec_bits !== want.rec_bits) begin
      $error("rec_bits: expected %0d, got %0d", want.rec_bits, got.rec_bits);
      n_fail++;
    end
    if (got.rec_count !== want.rec_count) begin
      $error("rec_count: expected %0d, got %0d", want.rec_count, got.rec_count);
      n_fail++;
    end
  endtask

  // Each strobed result pairs with the oldest pending expectation.
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result with no item pending: %h", result_o);
        n_fail++;
      end else begin
        check_result(pending_results.pop_front(), result_o);
      end
    end
  end

  // Stop a hung run well past the slowest legal one.
  initial begin
    #100_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int unsigned ph;
    int unsigned i;

    clk_i = 1'b0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    item_i = '0;
    shadow_used = 0;
    n_fail = 0;
    idle_pct = 0;
    refresh_pool();

    // Directed rows: typed results where they are obvious, predictor elsewhere.
    dir_tab.push_back('{1'b1, mk_res(0, 1'b0, 1'b0),
                        mk_item(selt_pkg::ACT_READ, 32'h0, 2'd0, 3'd0, 8'd0)});
    dir_tab.push_back('{1'b1, mk_res(0, 1'b0, 1'b0),
                        mk_item(selt_pkg::ACT_CLEAR, 32'hFFFF_FFFF, 2'd3, 3'd7, 8'hFF)});
    dir_tab.push_back('{1'b1, mk_res(0, 1'b0, 1'b0),
                        mk_item(ACT_NONE, 32'hFFFF_FFFF, 2'd3, 3'd7, 8'hFF)});
    dir_tab.push_back('{1'b1, mk_res(1, 1'b0, 1'b0),
                        mk_item(selt_pkg::ACT_LOG, 32'h1000, 2'd1, 3'd1, 8'd0)});
    dir_tab.push_back('{1'b1, mk_res(1, 1'b1, 1'b0),
                        mk_item(selt_pkg::ACT_LOG, 32'h1000, 2'd1, 3'd2, 8'd0)});
    // Same address, other unit, no type bits: new record after the first.
    dir_tab.push_back('{1'b1, mk_res(2, 1'b0, 1'b0),
                        mk_item(selt_pkg::ACT_LOG, 32'h1000, 2'd2, 3'd0, 8'd0)});
    dir_tab.push_back('{1'b1, mk_res(3, 1'b0, 1'b0),
                        mk_item(selt_pkg::ACT_LOG, 32'h0, 2'd0, 3'd7, 8'hFF)});
    dir_tab.push_back('{1'b1, mk_res(4, 1'b0, 1'b0),
                        mk_item(selt_pkg::ACT_LOG, 32'hFFFF_FFFF, 2'd3, 3'd4, 8'h5A)});
    for (i = 0; i < 4; i++) begin
      dir_tab.push_back('{1'b0, mk_res(0, 1'b0, 1'b0),
                          mk_item(selt_pkg::ACT_READ, 32'hA5A5_A5A5, 2'd2, 3'd5, 8'(i))});
    end
    // Read past the end and an unknown action with busy fields.
    dir_tab.push_back('{1'b1, mk_res(4, 1'b0, 1'b0),
                        mk_item(selt_pkg::ACT_READ, 32'h0, 2'd0, 3'd0, 8'hFF)});
    dir_tab.push_back('{1'b1, mk_res(4, 1'b0, 1'b0),
                        mk_item(ACT_NONE, 32'h5A5A_5A5A, 2'd1, 3'd2, 8'd1)});
    dir_tab.push_back('{1'b1, mk_res(5, 1'b0, 1'b0),
                        mk_item(selt_pkg::ACT_LOG, 32'h1000, 2'd3, 3'd7, 8'd0)});
    dir_tab.push_back('{1'b0, mk_res(0, 1'b0, 1'b0),
                        mk_item(selt_pkg::ACT_READ, 32'h0, 2'd0, 3'd0, 8'd3)});
    dir_tab.push_back('{1'b1, mk_res(5, 1'b1, 1'b0),
                        mk_item(selt_pkg::ACT_LOG, 32'h0, 2'd0, 3'd0, 8'd0)});
    dir_tab.push_back('{1'b0, mk_res(0, 1'b0, 1'b0),
                        mk_item(selt_pkg::ACT_READ, 32'h0, 2'd0, 3'd0, 8'd0)});
    dir_tab.push_back('{1'b1, mk_res(0, 1'b0, 1'b0),
                        mk_item(selt_pkg::ACT_CLEAR, 32'h0, 2'd0, 3'd0, 8'd0)});
    dir_tab.push_back('{1'b1, mk_res(0, 1'b0, 1'b0),
                        mk_item(selt_pkg::ACT_READ, 32'h0, 2'd0, 3'd0, 8'd0)});
    dir_tab.push_back('{1'b1, mk_res(1, 1'b0, 1'b0),
                        mk_item(selt_pkg::ACT_LOG, 32'hFFFF_FFFF, 2'd3, 3'd7, 8'd0)});

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[row]) begin
      issue(dir_tab[row].stim, dir_tab[row].typed, dir_tab[row].want);
    end
    drain();

    for (ph = 0; ph < N_PHASES; ph++) begin
      idle_pct = SEND_IDLE_PCT[ph];
      repeat (PHASE_ITEMS) issue(random_item(), 1'b0, '0);

      if (ph == N_PHASES - 1) begin
        // Fill the table, then push logs, reads and drops against a full table.
        issue(mk_item(selt_pkg::ACT_CLEAR, 32'($urandom), 2'd0, 3'd0, 8'd0), 1'b0, '0);
        while (shadow_used < selt_pkg::LOG_DEPTH) begin
          issue(mk_item(selt_pkg::ACT_LOG, 32'($urandom), 2'($urandom_range(3)),
                        3'($urandom_range(7)), 8'($urandom)), 1'b0, '0);
        end
        issue(mk_item(selt_pkg::ACT_READ, 32'($urandom), 2'd0, 3'd0, 8'hFF), 1'b0, '0);
        issue(mk_item(selt_pkg::ACT_LOG, 32'($urandom), 2'($urandom_range(3)), 3'd7, 8'd0),
              1'b0, '0);
        repeat (40) issue(random_item(), 1'b0, '0);
      end

      // Pause the sender until every result of this phase has arrived.
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
